// ===== rtl/core/cmc_pkg.sv =====
// Package for the cube-map cross-atlas core: face codes, default widths
// and per-face atlas cell offsets. No dependencies.
`default_nettype none

package cmc_pkg;

  localparam int unsigned ComponentBitsDef = 16;
  localparam int unsigned FractionBitsDef  = 16;

  typedef enum logic [2:0] {
    FACE_PX = 3'd0,
    FACE_PY = 3'd1,
    FACE_PZ = 3'd2,
    FACE_NX = 3'd3,
    FACE_NY = 3'd4,
    FACE_NZ = 3'd5
  } face_e;

  // Horizontal cell offset of a face in the 4x3 cross
  function automatic logic [1:0] cell_u(input logic [2:0] face);
    logic [1:0] off;
    case (face)
      FACE_PX: off = 2'd2;
      FACE_PY: off = 2'd1;
      FACE_PZ: off = 2'd1;
      FACE_NX: off = 2'd0;
      FACE_NY: off = 2'd1;
      FACE_NZ: off = 2'd3;
      default: off = 2'd0;
    endcase
    return off;
  endfunction

  // Vertical cell offset of a face in the 4x3 cross
  function automatic logic [1:0] cell_v(input logic [2:0] face);
    logic [1:0] off;
    case (face)
      FACE_PX: off = 2'd1;
      FACE_PY: off = 2'd2;
      FACE_PZ: off = 2'd1;
      FACE_NX: off = 2'd1;
      FACE_NY: off = 2'd0;
      FACE_NZ: off = 2'd1;
      default: off = 2'd0;
    endcase
    return off;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cmc_if.sv =====
// Handshake channels of the cube-map core: direction beats in, atlas
// results out. Depends on nothing.
`default_nettype none

interface cmc_dir_if #(
  parameter int unsigned ComponentBits = 16
);
  logic                            valid;
  logic                            ready;
  logic signed [ComponentBits-1:0] dir_x;
  logic signed [ComponentBits-1:0] dir_y;
  logic signed [ComponentBits-1:0] dir_z;

  modport source (output valid, dir_x, dir_y, dir_z, input ready);
  modport sink   (input valid, dir_x, dir_y, dir_z, output ready);
endinterface

interface cmc_res_if #(
  parameter int unsigned FractionBits = 16
);
  logic                    valid;
  logic                    ready;
  logic [2:0]              face;
  logic [FractionBits-1:0] atlas_u;
  logic [FractionBits-1:0] atlas_v;
  logic                    valid_res;

  modport source (output valid, face, atlas_u, atlas_v, valid_res, input ready);
  modport sink   (input valid, face, atlas_u, atlas_v, valid_res, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cmc_front.sv =====
// Front end: picks the cube face of a direction and the major magnitude
// and minor numerators. Depends on cmc_pkg.
`default_nettype none

module cmc_front import cmc_pkg::*; #(
  parameter int unsigned ComponentBits = ComponentBitsDef
) (
  input  wire logic signed [ComponentBits-1:0] dir_x_i,
  input  wire logic signed [ComponentBits-1:0] dir_y_i,
  input  wire logic signed [ComponentBits-1:0] dir_z_i,
  output logic                                 ok_o,
  output logic             [2:0]               face_o,
  output logic             [ComponentBits-1:0] mag_o,
  output logic signed      [ComponentBits:0]   num_u_o,
  output logic signed      [ComponentBits:0]   num_v_o
);

  localparam int unsigned EW = ComponentBits + 1;

  logic signed [EW-1:0] x, y, z, nx, ny, nz, m_s;

  assign x  = EW'(dir_x_i);
  assign y  = EW'(dir_y_i);
  assign z  = EW'(dir_z_i);
  assign nx = -x;
  assign ny = -y;
  assign nz = -z;

  // Face tests; the first test that passes wins over the later ones
  always_comb begin
    ok_o   = 1'b0;
    face_o = FACE_PX;
    if (nz > x && nz >= nx && nz >= y && nz > ny) begin
      ok_o = 1'b1; face_o = FACE_NZ;
    end else if (ny > x && ny >= nx && ny > z && ny >= nz) begin
      ok_o = 1'b1; face_o = FACE_NY;
    end else if (nx >= y && nx > ny && nx >= z && nx > nz) begin
      ok_o = 1'b1; face_o = FACE_NX;
    end else if (z >= x && z > nx && z > y && z >= ny) begin
      ok_o = 1'b1; face_o = FACE_PZ;
    end else if (y >= x && y > nx && y >= z && y > nz) begin
      ok_o = 1'b1; face_o = FACE_PY;
    end else if (x > y && x >= ny && x > z && x >= nz) begin
      ok_o = 1'b1; face_o = FACE_PX;
    end
  end

  // Major magnitude and per-face minor numerators
  always_comb begin
    m_s     = x;
    num_u_o = nz;
    num_v_o = y;
    case (face_o)
      FACE_PX: begin m_s = x;  num_u_o = nz; num_v_o = y;  end
      FACE_PY: begin m_s = y;  num_u_o = x;  num_v_o = nz; end
      FACE_PZ: begin m_s = z;  num_u_o = x;  num_v_o = y;  end
      FACE_NX: begin m_s = nx; num_u_o = z;  num_v_o = y;  end
      FACE_NY: begin m_s = ny; num_u_o = x;  num_v_o = z;  end
      FACE_NZ: begin m_s = nz; num_u_o = nx; num_v_o = y;  end
      default: begin m_s = x;  num_u_o = nz; num_v_o = y;  end
    endcase
  end

  // Magnitude is positive when a face matched, at most 2^(C-1)
  assign mag_o = m_s[ComponentBits-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/cmc_queue.sv =====
// Two-entry queue between the front end and the divider back end.
// Depends on cmc_pkg only for house consistency of defaults.
`default_nettype none

module cmc_queue import cmc_pkg::*; #(
  parameter int unsigned DataBits = ComponentBitsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire logic [DataBits-1:0] data_i,
  output logic                     full_o,
  input  wire logic                pop_i,
  output logic                     avail_o,
  output logic      [DataBits-1:0] data_o
);

  logic [DataBits-1:0] mem_q [2];
  logic                wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]          cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign avail_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && avail_o;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cmc_back.sv =====
// Back end: forms the atlas numerators and denominators, then runs two
// restoring dividers, one quotient bit per stage. Depends on cmc_pkg.
`default_nettype none

module cmc_back import cmc_pkg::*; #(
  parameter int unsigned ComponentBits = ComponentBitsDef,
  parameter int unsigned FractionBits  = FractionBitsDef
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                avail_i,
  output logic                                     pop_o,
  input  wire logic                                ok_i,
  input  wire logic            [2:0]               face_i,
  input  wire logic            [ComponentBits-1:0] mag_i,
  input  wire logic signed     [ComponentBits:0]   num_u_i,
  input  wire logic signed     [ComponentBits:0]   num_v_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic                 [2:0]               face_o,
  output logic                 [FractionBits-1:0]  atlas_u_o,
  output logic                 [FractionBits-1:0]  atlas_v_o,
  output logic                                     valid_res_o
);

  localparam int unsigned W      = ComponentBits + 3;
  localparam int unsigned Stages = FractionBits + 2;

  typedef struct packed {
    logic                  ok;
    logic [2:0]            face;
    logic [W-1:0]          den_u;
    logic [W-1:0]          den_v;
    logic [W-1:0]          rem_u;
    logic [W-1:0]          rem_v;
    logic [FractionBits:0] quo_u;
    logic [FractionBits:0] quo_v;
  } stg_t;

  stg_t pipe_q [Stages];
  stg_t pipe_d [Stages];
  logic vld_q  [Stages];
  logic adv;

  // Whole pipeline moves when the output register is free or drained
  assign adv   = !out_valid_o || out_ready_i;
  assign pop_o = adv && avail_i;

  // Setup: clamp p+m to [0,2m], add cell offset, form 8m and 6m
  logic signed [ComponentBits+1:0] qs;
  logic signed [ComponentBits+1:0] qv;
  logic        [ComponentBits:0]   two_m;
  logic        [W-1:0]             m_w, cu_w, cv_w, off_u, off_v;
  logic        [1:0]               uo, vo;

  always_comb begin
    two_m = {mag_i, 1'b0};
    m_w   = W'(mag_i);
    uo    = cell_u(face_i);
    vo    = cell_v(face_i);
    qs    = (ComponentBits+2)'(num_u_i) + (ComponentBits+2)'(mag_i);
    qv    = (ComponentBits+2)'(num_v_i) + (ComponentBits+2)'(mag_i);
    if (qs < 0) cu_w = '0;
    else if (qs > $signed({1'b0, two_m})) cu_w = W'(two_m);
    else cu_w = W'(qs[ComponentBits:0]);
    if (qv < 0) cv_w = '0;
    else if (qv > $signed({1'b0, two_m})) cv_w = W'(two_m);
    else cv_w = W'(qv[ComponentBits:0]);
    off_u = (uo[0] ? (m_w << 1) : '0) + (uo[1] ? (m_w << 2) : '0);
    off_v = (vo[0] ? (m_w << 1) : '0) + (vo[1] ? (m_w << 2) : '0);
    pipe_d[0].ok    = ok_i;
    pipe_d[0].face  = face_i;
    pipe_d[0].den_u = m_w << 3;
    pipe_d[0].den_v = (m_w << 2) + (m_w << 1);
    pipe_d[0].rem_u = cu_w + off_u;
    pipe_d[0].rem_v = cv_w + off_v;
    pipe_d[0].quo_u = '0;
    pipe_d[0].quo_v = '0;
  end

  // Integer bit first (no doubling), then one fraction bit per stage
  for (genvar k = 1; k < Stages; k++) begin : g_div
    logic [W:0] tu, tv;
    logic       bu, bv;
    always_comb begin
      if (k == 1) begin
        tu = {1'b0, pipe_q[k-1].rem_u};
        tv = {1'b0, pipe_q[k-1].rem_v};
      end else begin
        tu = {pipe_q[k-1].rem_u, 1'b0};
        tv = {pipe_q[k-1].rem_v, 1'b0};
      end
      bu = tu >= {1'b0, pipe_q[k-1].den_u};
      bv = tv >= {1'b0, pipe_q[k-1].den_v};
      pipe_d[k]       = pipe_q[k-1];
      pipe_d[k].rem_u = bu ? W'(tu - {1'b0, pipe_q[k-1].den_u}) : W'(tu);
      pipe_d[k].rem_v = bv ? W'(tv - {1'b0, pipe_q[k-1].den_v}) : W'(tv);
      pipe_d[k].quo_u = {pipe_q[k-1].quo_u[FractionBits-1:0], bu};
      pipe_d[k].quo_v = {pipe_q[k-1].quo_v[FractionBits-1:0], bv};
    end
  end

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Stages; i++) vld_q[i] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= avail_i;
      for (int i = 1; i < Stages; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < Stages; i++) pipe_q[i] <= pipe_d[i];
    end
  end

  // Saturate at the top edge, zero for a zero vector, then register
  stg_t last;
  logic [FractionBits-1:0] sat_u, sat_v;
  assign last  = pipe_q[Stages-1];
  assign sat_u = last.quo_u[FractionBits] ? '1 : last.quo_u[FractionBits-1:0];
  assign sat_v = last.quo_v[FractionBits] ? '1 : last.quo_v[FractionBits-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= vld_q[Stages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      face_o      <= last.ok ? last.face : FACE_PX;
      atlas_u_o   <= last.ok ? sat_u : '0;
      atlas_v_o   <= last.ok ? sat_v : '0;
      valid_res_o <= last.ok;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cube_map_cross_coordinates_core.sv =====
// Top level of the cube-map cross-atlas core: front end, queue, divider
// back end. Depends on cmc_pkg, cmc_if, cmc_front, cmc_queue, cmc_back.
//
// Takes one direction beat per cycle while the queue has room and returns,
// per beat, the cube face and its coordinates in a 4x3 cross atlas as
// unsigned fractions. A zero vector returns valid_res = 0 with zero face
// and coordinates. Throughput is one beat per cycle while the output is
// not stalled. Each beat passes through the queue, one setup stage,
// FRACTION_BITS + 1 divider stages (the two restoring dividers resolve one
// quotient bit per stage) and the output register. A two-entry queue sits
// between face selection and the dividers; a stalled output halts the
// divider pipeline and backs up the queue until the input ready drops.
`default_nettype none

module cube_map_cross_coordinates_core import cmc_pkg::*; #(
  parameter int unsigned COMPONENT_BITS = ComponentBitsDef,
  parameter int unsigned FRACTION_BITS  = FractionBitsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cmc_dir_if.sink   in_i,
  cmc_res_if.source out_o
);

  localparam int unsigned QW = 1 + 3 + COMPONENT_BITS + 2 * (COMPONENT_BITS + 1);

  logic                            f_ok;
  logic [2:0]                      f_face;
  logic [COMPONENT_BITS-1:0]       f_mag;
  logic signed [COMPONENT_BITS:0]  f_nu, f_nv;
  logic                            q_full, q_avail, b_pop;
  logic [QW-1:0]                   q_out;
  logic signed [COMPONENT_BITS:0]  b_nu, b_nv;

  // Face selection
  cmc_front #(.ComponentBits(COMPONENT_BITS)) u_front (
    .dir_x_i (in_i.dir_x),
    .dir_y_i (in_i.dir_y),
    .dir_z_i (in_i.dir_z),
    .ok_o    (f_ok),
    .face_o  (f_face),
    .mag_o   (f_mag),
    .num_u_o (f_nu),
    .num_v_o (f_nv)
  );

  assign in_i.ready = !q_full;

  // Decoupling queue
  cmc_queue #(.DataBits(QW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_i.valid),
    .data_i  ({f_ok, f_face, f_mag, f_nu, f_nv}),
    .full_o  (q_full),
    .pop_i   (b_pop),
    .avail_o (q_avail),
    .data_o  (q_out)
  );

  assign b_nu = q_out[2*COMPONENT_BITS+1:COMPONENT_BITS+1];
  assign b_nv = q_out[COMPONENT_BITS:0];

  // Divider back end
  cmc_back #(
    .ComponentBits(COMPONENT_BITS),
    .FractionBits (FRACTION_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (q_avail),
    .pop_o       (b_pop),
    .ok_i        (q_out[QW-1]),
    .face_i      (q_out[QW-2:QW-4]),
    .mag_i       (q_out[QW-5:2*COMPONENT_BITS+2]),
    .num_u_i     (b_nu),
    .num_v_i     (b_nv),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .face_o      (out_o.face),
    .atlas_u_o   (out_o.atlas_u),
    .atlas_v_o   (out_o.atlas_v),
    .valid_res_o (out_o.valid_res)
  );

endmodule

`default_nettype wire
